/* hdl/bfbp_pkg.sv */
// Shared types and constants for the best-fit bin packer.
`default_nettype none

package bfbp_pkg;

   // Field widths fixed by the request and response formats
   localparam int unsigned WeightWidth = 16;
   localparam int unsigned IndexWidth  = 7;
   localparam int unsigned CountWidth  = 8;
   localparam int unsigned StatusWidth = 2;

   // Response status codes
   typedef enum logic [StatusWidth-1:0] {
      STATUS_PLACED     = 2'd0,
      STATUS_OVERWEIGHT = 2'd1,
      STATUS_FULL       = 2'd2
   } status_type;

   // One request: an item to place
   typedef struct packed {
      logic [WeightWidth-1:0] item_weight;
      logic                   last_item;
   } req_payload_type;

   // One response: where the item went
   typedef struct packed {
      logic [IndexWidth-1:0]  bin_index;
      logic                   opened_new;
      logic [CountWidth-1:0]  bins_in_use;
      logic [StatusWidth-1:0] status;
      logic                   set_done;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* hdl/bfbp_if.sv */
// Valid/ready channel interfaces for the bin packer requests and responses.
`default_nettype none

interface bfbp_req_if;
   logic                     valid;
   logic                     ready;
   bfbp_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bfbp_rsp_if;
   logic                     valid;
   logic                     ready;
   bfbp_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/best_fit_bin_packer.sv */
// Best-fit bin packer: places item weights into bins, one request at a time.
//
// Channels: req_chan takes one request (item_weight, last_item) per accept;
// rsp_chan returns exactly one response per request (bin_index, opened_new,
// bins_in_use, status, set_done). csr_wr_en/csr_wr_data write bin_capacity.
// Each request that is not overweight scans the n currently open bins through
// the remaining-space memory, one entry per cycle on its single registered read
// port, keeping the tightest fit in one shared subtract/compare unit, then writes
// back one entry if the item is placed. The response becomes valid at the same
// edge that raises req_chan.ready again, so a new request is taken only once the
// previous one is done.
// req_chan.ready is high only while no request is in progress.
// The response sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, the following request finishes its scan
// and holds in the final step until the output register frees up.
// Reset clears the open bin count, sets bin_capacity to 65535 and empties the
// output register; the memory needs no clearing since only entries below the
// open bin count are read, each written when its bin opens. A request with
// last_item set returns its final count and then empties the bin table.
`default_nettype none

module best_fit_bin_packer #(
   parameter int unsigned MAX_BINS = 128
) (
   input  wire logic              clock,
   input  wire logic              reset,
   bfbp_req_if.sink               req_chan,
   bfbp_rsp_if.source             rsp_chan,
   input  wire logic              csr_wr_en,
   input  wire logic [15:0]       csr_wr_data
);

   localparam int unsigned AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int unsigned CW = $clog2(MAX_BINS + 1);
   localparam int unsigned WW = bfbp_pkg::WeightWidth;
   localparam int unsigned IW = bfbp_pkg::IndexWidth;
   localparam int unsigned NW = bfbp_pkg::CountWidth;
   localparam logic [CW-1:0] MaxCount = CW'(MAX_BINS);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // Registers
   state_type       state_ff, state_in;
   logic [WW-1:0]   cap_ff, cap_in;
   logic [WW-1:0]   weight_ff, weight_in;
   logic            last_ff, last_in;
   logic            over_ff, over_in;
   logic [CW-1:0]   addr_ff, addr_in;
   logic            pend_ff, pend_in;
   logic [AW-1:0]   pend_idx_ff, pend_idx_in;
   logic            found_ff, found_in;
   logic [AW-1:0]   best_ff, best_in;
   logic [WW-1:0]   best_slack_ff, best_slack_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   bfbp_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // Memory
   logic [WW-1:0]   space_mem [MAX_BINS];
   logic [WW-1:0]   rd_data_ff;
   logic            rd_en;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [WW-1:0]   wr_data;

   // Handshakes and the shared compare unit
   logic            req_fire;
   logic            out_free;
   logic            fits;
   logic [WW-1:0]   slack;
   logic            finish_go;
   logic [AW-1:0]   res_idx;
   logic [CW-1:0]   res_count;
   logic [AW+IW-1:0] idx_ext;
   logic [CW+NW-1:0] count_ext;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Compare the entry read last cycle against the current weight
   assign fits  = rd_data_ff >= weight_ff;
   assign slack = rd_data_ff - weight_ff;

   assign rd_en     = (state_ff == ST_SCAN) && (addr_ff < count_ff);
   assign finish_go = (state_ff == ST_FINISH) && out_free;

   // Pick the outcome and the memory write-back
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = best_ff;
      wr_data   = best_slack_ff;
      res_idx   = '0;
      res_count = count_ff;
      rsp_data_in.opened_new = 1'b0;
      rsp_data_in.status     = bfbp_pkg::STATUS_PLACED;
      if (over_ff) begin
         rsp_data_in.status = bfbp_pkg::STATUS_OVERWEIGHT;
      end else if (found_ff) begin
         wr_en   = finish_go;
         res_idx = best_ff;
      end else if (count_ff == MaxCount) begin
         rsp_data_in.status = bfbp_pkg::STATUS_FULL;
      end else begin
         wr_en     = finish_go;
         wr_addr   = count_ff[AW-1:0];
         wr_data   = cap_ff - weight_ff;
         res_idx   = count_ff[AW-1:0];
         res_count = count_ff + CW'(1);
         rsp_data_in.opened_new = 1'b1;
      end
      idx_ext   = {{IW{1'b0}}, res_idx};
      count_ext = {{NW{1'b0}}, res_count};
      rsp_data_in.bin_index   = idx_ext[IW-1:0];
      rsp_data_in.bins_in_use = count_ext[NW-1:0];
      rsp_data_in.set_done    = last_ff;
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cap_in        = csr_wr_en ? csr_wr_data : cap_ff;
      weight_in     = weight_ff;
      last_in       = last_ff;
      over_in       = over_ff;
      addr_in       = addr_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_slack_in = best_slack_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         ST_IDLE: begin
            // take a request and arm the scan
            if (req_fire) begin
               weight_in = req_chan.payload.item_weight;
               last_in   = req_chan.payload.last_item;
               over_in   = req_chan.payload.item_weight > cap_ff;
               addr_in   = '0;
               pend_in   = 1'b0;
               found_in  = 1'b0;
               state_in  = (req_chan.payload.item_weight > cap_ff) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // keep the tightest fit, lowest index on a tie
            if (pend_ff && fits && (!found_ff || slack < best_slack_ff)) begin
               found_in      = 1'b1;
               best_in       = pend_idx_ff;
               best_slack_in = slack;
            end
            // advance the read address until every open bin is issued
            if (rd_en) begin
               pend_in     = 1'b1;
               pend_idx_in = addr_ff[AW-1:0];
               addr_in     = addr_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               count_in     = last_ff ? '0 : res_count;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= '1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      weight_ff     <= weight_in;
      last_ff       <= last_in;
      over_ff       <= over_in;
      addr_ff       <= addr_in;
      pend_ff       <= pend_in;
      pend_idx_ff   <= pend_idx_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      best_slack_ff <= best_slack_in;
      if (finish_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Remaining-space memory: one registered read, one write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= space_mem[addr_ff[AW-1:0]];
      end
      if (wr_en) begin
         space_mem[wr_addr] <= wr_data;
      end
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxCount)
      else $error("open bin count beyond table size");

   a_scan_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (addr_ff <= count_ff))
      else $error("scan address ran past the open bins");

   a_set_clear: assert property (@(posedge clock) disable iff (reset)
      (finish_go && last_ff) |=> (count_ff == '0))
      else $error("bin table not cleared after last item");

   a_new_placed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.opened_new) |->
      (rsp_data_ff.status == bfbp_pkg::STATUS_PLACED))
      else $error("new bin flagged on an unplaced item");

endmodule

`default_nettype wire

/* test/best_fit_bin_packer_tb.sv */
// Self-checking testbench for the best-fit bin packer: directed and random requests.

module best_fit_bin_packer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TableDepth   = 128;
   localparam int CycleLimit   = 1_500_000;
   localparam int DrainCycles  = 300;
   localparam int RandomTarget = 900;
   localparam int MaxWeight    = 65535;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [15:0] csr_wr_data;

   bfbp_req_if req_if ();
   bfbp_rsp_if rsp_if ();

   best_fit_bin_packer #(
      .MAX_BINS (TableDepth)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Packing state mirrored from the block
   logic [bfbp_pkg::WeightWidth-1:0] bin_space [TableDepth];
   logic [bfbp_pkg::WeightWidth-1:0] bin_capacity;
   int open_bins;

   // Expected responses, oldest first
   bfbp_pkg::rsp_payload_type placement_q [$];
   bfbp_pkg::rsp_payload_type got_rsp;
   bfbp_pkg::rsp_payload_type want_rsp;

   int idle_max;
   int rsp_hold_cycles;
   int cycle_count;
   int error_count;
   int requests_sent;
   int sets_sent;
   int responses_checked;
   int overweight_seen;
   int full_seen;
   int new_bins_seen;
   int capacity_writes;
   int peak_bins;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle counter and watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      while (cycle_count < CycleLimit) @(posedge clock);
      $display("Timeout after %0d cycles, %0d responses outstanding",
               cycle_count, placement_q.size());
      $display("*** FAILED ***");
      $finish;
   end

   // Count down a receiver hold-off
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) rsp_hold_cycles <= rsp_hold_cycles - 1;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Best-fit placement of one item; updates the mirrored table
   function automatic bfbp_pkg::rsp_payload_type place_item(
         input logic [bfbp_pkg::WeightWidth-1:0] weight, input logic last);
      bfbp_pkg::rsp_payload_type res;
      logic found;
      int best;
      logic [bfbp_pkg::WeightWidth-1:0] best_slack;
      res = '0;
      found = 1'b0;
      best = 0;
      best_slack = '0;
      if (weight > bin_capacity) begin
         res.status = bfbp_pkg::STATUS_OVERWEIGHT;
      end else begin
         // Tightest fit wins; strict compare keeps the lowest bin on a tie
         for (int j = 0; j < open_bins; j++) begin
            if (bin_space[j] >= weight && (!found || bin_space[j] - weight < best_slack)) begin
               found = 1'b1;
               best = j;
               best_slack = bin_space[j] - weight;
            end
         end
         if (found) begin
            bin_space[best] = best_slack;
            res.bin_index = best[bfbp_pkg::IndexWidth-1:0];
         end else if (open_bins >= TableDepth) begin
            res.status = bfbp_pkg::STATUS_FULL;
         end else begin
            res.bin_index = open_bins[bfbp_pkg::IndexWidth-1:0];
            bin_space[open_bins] = bin_capacity - weight;
            open_bins++;
            res.opened_new = 1'b1;
         end
      end
      res.bins_in_use = open_bins[bfbp_pkg::CountWidth-1:0];
      res.set_done = last;
      if (last) open_bins = 0;
      return res;
   endfunction

   // Offer one request after a random gap; predict on acceptance
   task automatic send_item(input logic [bfbp_pkg::WeightWidth-1:0] weight, input logic last);
      bfbp_pkg::rsp_payload_type want;
      int gap;
      gap = $urandom_range(0, idle_max);
      @(negedge clock);
      repeat (gap) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.payload.item_weight <= weight;
      req_if.payload.last_item <= last;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      want = place_item(weight, last);
      placement_q.push_back(want);
      requests_sent++;
      if (last) sets_sent++;
      if (want.status == bfbp_pkg::STATUS_OVERWEIGHT) overweight_seen++;
      if (want.status == bfbp_pkg::STATUS_FULL) full_seen++;
      if (want.opened_new) new_bins_seen++;
      if (int'(want.bins_in_use) > peak_bins) peak_bins = want.bins_in_use;
   endtask

   // Drop valid so a held request is not taken twice
   task automatic req_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   // Write bin capacity once the block has returned every response
   task automatic write_capacity(input logic [15:0] value);
      req_idle();
      while (placement_q.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      bin_capacity = value;
      capacity_writes++;
   endtask

   function automatic logic [15:0] draw_capacity();
      case ($urandom_range(0, 4))
         0: return 16'd1;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(2, 255));
         3: return 16'($urandom_range(256, MaxWeight - 1));
         default: return 16'($urandom_range(1, MaxWeight));
      endcase
   endfunction

   function automatic logic [bfbp_pkg::WeightWidth-1:0] draw_weight();
      int cap;
      cap = bin_capacity;
      case ($urandom_range(0, 7)) inside
         0: return 16'($urandom_range(0, MaxWeight));
         1: return 16'(cap);
         2: return 16'd0;
         3: return (cap == MaxWeight) ? 16'hFFFF : 16'($urandom_range(cap + 1, MaxWeight));
         4, 5: return 16'($urandom_range(0, cap / 4));
         6: return 16'($urandom_range(0, cap));
         default: return 16'($urandom_range(cap / 2, cap));
      endcase
   endfunction

   // Response ready with random stalls and an optional long hold-off
   initial begin : drive_rsp_ready
      int stall;
      rsp_if.ready = 1'b0;
      forever begin
         stall = $urandom_range(0, idle_max);
         repeat (stall) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
         end
         @(negedge clock);
         while (rsp_hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
      end
   end

   // Compare each response with the oldest expectation
   always @(posedge clock) begin
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (placement_q.size() == 0) begin
            report_mismatch("response with no request pending", 1, 0);
         end else begin
            want_rsp = placement_q.pop_front();
            got_rsp = rsp_if.payload;
            if (got_rsp.bin_index !== want_rsp.bin_index)
               report_mismatch("bin_index", got_rsp.bin_index, want_rsp.bin_index);
            if (got_rsp.opened_new !== want_rsp.opened_new)
               report_mismatch("opened_new", got_rsp.opened_new, want_rsp.opened_new);
            if (got_rsp.bins_in_use !== want_rsp.bins_in_use)
               report_mismatch("bins_in_use", got_rsp.bins_in_use, want_rsp.bins_in_use);
            if (got_rsp.status !== want_rsp.status)
               report_mismatch("status", got_rsp.status, want_rsp.status);
            if (got_rsp.set_done !== want_rsp.set_done)
               report_mismatch("set_done", got_rsp.set_done, want_rsp.set_done);
            responses_checked++;
         end
      end
   end

   // Reset capacity of 65535: full-weight item, exact fit, zero weight
   task automatic test_reset_capacity();
      send_item(16'hFFFF, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd1, 1'b0);
      send_item(16'd32768, 1'b1);
   endtask

   // Overweight items place nothing but still clear on the last request
   task automatic test_overweight();
      write_capacity(16'd100);
      send_item(16'd101, 1'b0);
      send_item(16'd100, 1'b0);
      send_item(16'hFFFF, 1'b1);
      send_item(16'd1, 1'b1);
   endtask

   // Least slack wins; the lower bin wins a tie
   task automatic test_best_fit_and_ties();
      write_capacity(16'd100);
      send_item(16'd60, 1'b0);
      send_item(16'd60, 1'b0);
      send_item(16'd70, 1'b0);
      send_item(16'd40, 1'b0);
      send_item(16'd25, 1'b0);
      send_item(16'd30, 1'b1);
   endtask

   // Zero capacity: weight 0 opens and joins bins, anything else is overweight
   task automatic test_zero_capacity();
      write_capacity(16'd0);
      send_item(16'd0, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd1, 1'b0);
      send_item(16'd0, 1'b1);
   endtask

   // Open bins keep their space when the capacity drops within a set
   task automatic test_capacity_change_mid_set();
      write_capacity(16'd1000);
      send_item(16'd100, 1'b0);
      write_capacity(16'd10);
      send_item(16'd5, 1'b0);
      send_item(16'd20, 1'b0);
      send_item(16'd10, 1'b1);
      write_capacity(16'd1);
      send_item(16'd1, 1'b0);
      send_item(16'd1, 1'b1);
   endtask

   // Fill every bin with more than half the capacity, then overflow the table
   task automatic test_table_full(input logic [15:0] cap);
      int lo;
      write_capacity(cap);
      idle_max = 0;
      lo = int'(cap) / 2 + 1;
      for (int k = 0; k < TableDepth; k++) send_item(16'($urandom_range(lo, cap)), 1'b0);
      send_item(16'd0, 1'b0);
      send_item(cap, 1'b0);
      idle_max = 6;
      send_item(cap, 1'b1);
   endtask

   // Hold responses off while requests keep coming, so the input stalls
   task automatic test_response_backpressure();
      write_capacity(16'd500);
      rsp_hold_cycles <= 400;
      idle_max = 0;
      for (int k = 0; k < 12; k++) send_item(16'($urandom_range(0, 300)), k == 11);
      idle_max = 6;
   endtask

   // Random sets: mostly short, some long, capacity changes between and within sets
   task automatic test_random_sets(input int item_target);
      int sent;
      int set_len;
      sent = 0;
      while (sent < item_target) begin
         if ($urandom_range(0, 3) == 0) write_capacity(draw_capacity());
         idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
         set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 140) : $urandom_range(1, 24);
         for (int k = 0; k < set_len; k++) begin
            if ($urandom_range(0, 60) == 0) write_capacity(draw_capacity());
            send_item(draw_weight(), k == set_len - 1);
            sent++;
         end
      end
      idle_max = 6;
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      bin_capacity = 16'hFFFF;
      open_bins = 0;
      idle_max = 6;
      rsp_hold_cycles = 0;
      cycle_count = 0;
      error_count = 0;
      requests_sent = 0;
      sets_sent = 0;
      responses_checked = 0;
      overweight_seen = 0;
      full_seen = 0;
      new_bins_seen = 0;
      capacity_writes = 0;
      peak_bins = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_capacity();
      test_overweight();
      test_best_fit_and_ties();
      test_zero_capacity();
      test_capacity_change_mid_set();
      test_table_full(16'hFFFF);
      test_table_full(16'($urandom_range(2, MaxWeight)));
      test_response_backpressure();
      test_random_sets(RandomTarget);

      // Drain, then watch for stray responses
      req_idle();
      while (placement_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Checked %0d responses for %0d requests in %0d sets, %0d capacity writes.",
               responses_checked, requests_sent, sets_sent, capacity_writes);
      $display("New bins %0d, overweight %0d, table full %0d, peak bins in use %0d.",
               new_bins_seen, overweight_seen, full_seen, peak_bins);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
